// File: rtl/core/scanner_telegram_deframer_crc16_defines.svh
// Assertion macros shared by the telegram deframer RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef SCANNER_TELEGRAM_DEFRAMER_CRC16_DEFINES_SVH
`define SCANNER_TELEGRAM_DEFRAMER_CRC16_DEFINES_SVH

// Checks a property on every rising clock edge outside of reset.
`define STDC16_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define STDC16_ASSERT_IMPL(lbl, ante, cons, msg) \
	`STDC16_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: rtl/core/stdc16_pkg.sv
// Package for the telegram deframer: frame limits, codes, result type and CRC step.
// Used by the top, parser and output stage of the deframer; depends on nothing else.
package stdc16_pkg;

	localparam int unsigned MAX_FRAME_BYTES = 1024;
	localparam int unsigned LEN_W = $clog2(MAX_FRAME_BYTES);

	localparam logic [7:0] START_BYTE = 8'h02;
	localparam logic [7:0] REPLY_ADDRESS_RST = 8'h80;
	localparam logic [15:0] CRC_POLY = 16'h8005;
	// A length above this value makes the telegram longer than the limit.
	localparam logic [16:0] LEN_LIMIT = 17'(MAX_FRAME_BYTES - 6);
	localparam logic [15:0] LEN_MIN = 16'd2;

	typedef enum logic [2:0] {
		KIND_DATA     = 3'd0,
		KIND_OK       = 3'd1,
		KIND_BAD_ADDR = 3'd2,
		KIND_CRC_BAD  = 3'd3,
		KIND_TOO_LONG = 3'd4
	} kind_t;

	typedef enum logic [7:0] {
		PH_HUNT = 8'b0000_0001,
		PH_ADDR = 8'b0000_0010,
		PH_LENL = 8'b0000_0100,
		PH_LENH = 8'b0000_1000,
		PH_CMD  = 8'b0001_0000,
		PH_BODY = 8'b0010_0000,
		PH_CRCL = 8'b0100_0000,
		PH_CRCH = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] data_word;
		logic [7:0]  reply_code;
		logic [7:0]  frame_status;
		logic        last_of_frame;
	} result_t;

	// One CRC step: shift left, fold in the polynomial on carry, then XOR the
	// previous byte and the current byte as one 16-bit word.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] prev,
		input logic [7:0] b);
		logic [15:0] c;
		c = {crc[14:0], 1'b0};
		if (crc[15]) begin
			c = c ^ CRC_POLY;
		end
		return c ^ {prev, b};
	endfunction

endpackage

// File: rtl/core/scanner_telegram_deframer_crc16.sv
// A byte beat is held in the input register and its result in the output register.
// Throughput: one byte beat per cycle unless a result beat waits on m_tready.
// The running CRC is updated once per byte from the start byte through the body.
// Reset (arst_n low, asynchronous) empties both registers, returns the parser to
// start-byte hunting and sets the reply address to 0x80.
module scanner_telegram_deframer_crc16 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,   // reply_address
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // data_word, reply_code, frame_status
	output logic [2:0]  m_tuser,     // kind
	output logic        m_tlast      // last_of_frame
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                take;
	logic                out_free;
	logic                res_valid;
	stdc16_pkg::result_t res;

	stdc16_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	stdc16_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.out_free  (out_free),
		.take      (take),
		.res_valid (res_valid),
		.res       (res)
	);

	stdc16_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// File: rtl/core/stdc16_in_stage.sv
// Input register of the telegram deframer: holds one received byte until the parser takes it.
// Depends on nothing but the clock and reset.
module stdc16_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // data_byte
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

// File: rtl/core/stdc16_parser.sv
// Frame parser of the telegram deframer: phase machine, running CRC and result forming.
// Depends on stdc16_pkg and the assertion macros header.
`include "scanner_telegram_deframer_crc16_defines.svh"

module stdc16_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	input  logic                valid_s1,
	input  logic [7:0]          byte_s1,
	input  logic                out_free,
	output logic                take,
	output logic                res_valid,
	output stdc16_pkg::result_t res
);

	stdc16_pkg::phase_t phase_q, phase_d;
	logic [7:0]  reply_address_q;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  prev_q;
	logic        feed;
	logic [stdc16_pkg::LEN_W-1:0] bytes_left_q;
	logic [7:0]  low_q;
	logic [7:0]  cmd_q;
	logic [7:0]  stat_q;
	logic        odd_q;
	logic [15:0] len;
	logic [15:0] len_clip;
	logic        too_long;

	assign take = valid_s1 && out_free;
	assign len = {byte_s1, low_q};
	assign too_long = ({1'b0, len} > stdc16_pkg::LEN_LIMIT);
	assign len_clip = (len < stdc16_pkg::LEN_MIN) ? stdc16_pkg::LEN_MIN : len;
	assign crc_d = stdc16_pkg::crc_feed(crc_q, prev_q, byte_s1);

	always_comb begin
		phase_d = phase_q;
		feed = 1'b0;
		res_valid = 1'b0;
		res = '{kind: stdc16_pkg::KIND_DATA, data_word: 16'd0, reply_code: 8'd0,
			frame_status: 8'd0, last_of_frame: 1'b0};
		case (phase_q)
			stdc16_pkg::PH_HUNT: begin
				if (byte_s1 == stdc16_pkg::START_BYTE) begin
					phase_d = stdc16_pkg::PH_ADDR;
				end
			end
			stdc16_pkg::PH_ADDR: begin
				if (byte_s1 != reply_address_q) begin
					phase_d = stdc16_pkg::PH_HUNT;
					res_valid = 1'b1;
					res.kind = stdc16_pkg::KIND_BAD_ADDR;
					res.last_of_frame = 1'b1;
				end else begin
					feed = 1'b1;
					phase_d = stdc16_pkg::PH_LENL;
				end
			end
			stdc16_pkg::PH_LENL: begin
				feed = 1'b1;
				phase_d = stdc16_pkg::PH_LENH;
			end
			stdc16_pkg::PH_LENH: begin
				feed = 1'b1;
				if (too_long) begin
					phase_d = stdc16_pkg::PH_HUNT;
					res_valid = 1'b1;
					res.kind = stdc16_pkg::KIND_TOO_LONG;
					res.last_of_frame = 1'b1;
				end else begin
					phase_d = stdc16_pkg::PH_CMD;
				end
			end
			stdc16_pkg::PH_CMD: begin
				feed = 1'b1;
				phase_d = stdc16_pkg::PH_BODY;
			end
			stdc16_pkg::PH_BODY: begin
				feed = 1'b1;
				if (bytes_left_q <= stdc16_pkg::LEN_W'(1)) begin
					phase_d = stdc16_pkg::PH_CRCL;
				end else if (odd_q) begin
					res_valid = 1'b1;
					res.data_word = {byte_s1, low_q};
					res.reply_code = cmd_q;
				end
			end
			stdc16_pkg::PH_CRCL: begin
				phase_d = stdc16_pkg::PH_CRCH;
			end
			stdc16_pkg::PH_CRCH: begin
				phase_d = stdc16_pkg::PH_HUNT;
				res_valid = 1'b1;
				res.kind = ({byte_s1, low_q} == crc_q) ? stdc16_pkg::KIND_OK
					: stdc16_pkg::KIND_CRC_BAD;
				res.reply_code = cmd_q;
				res.frame_status = stat_q;
				res.last_of_frame = 1'b1;
			end
			default: begin
				phase_d = stdc16_pkg::PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= stdc16_pkg::PH_HUNT;
			reply_address_q <= stdc16_pkg::REPLY_ADDRESS_RST;
		end else begin
			if (cfg_we) begin
				reply_address_q <= cfg_wdata;
			end
			if (take) begin
				phase_q <= phase_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (phase_q == stdc16_pkg::PH_HUNT && byte_s1 == stdc16_pkg::START_BYTE) begin
				crc_q <= stdc16_pkg::crc_feed(16'd0, 8'd0, byte_s1);
				prev_q <= byte_s1;
				cmd_q <= 8'd0;
				stat_q <= 8'd0;
			end else if (feed) begin
				crc_q <= crc_d;
				prev_q <= byte_s1;
			end
			case (phase_q)
				stdc16_pkg::PH_LENL: begin
					low_q <= byte_s1;
				end
				stdc16_pkg::PH_LENH: begin
					bytes_left_q <= stdc16_pkg::LEN_W'(len_clip - 16'd1);
				end
				stdc16_pkg::PH_CMD: begin
					cmd_q <= byte_s1;
					odd_q <= 1'b0;
				end
				stdc16_pkg::PH_BODY: begin
					if (bytes_left_q <= stdc16_pkg::LEN_W'(1)) begin
						stat_q <= byte_s1;
						bytes_left_q <= '0;
					end else begin
						bytes_left_q <= bytes_left_q - stdc16_pkg::LEN_W'(1);
						odd_q <= !odd_q;
						if (!odd_q) begin
							low_q <= byte_s1;
						end
					end
				end
				stdc16_pkg::PH_CRCL: begin
					low_q <= byte_s1;
				end
				default: begin
				end
			endcase
		end
	end

	`STDC16_ASSERT(a_close_to_hunt, take && res_valid && res.last_of_frame |=> phase_q == stdc16_pkg::PH_HUNT, "closing result did not return the parser to hunting")
	`STDC16_ASSERT_IMPL(a_body_count, phase_q == stdc16_pkg::PH_BODY, bytes_left_q != '0, "body phase with no bytes left")
	`STDC16_ASSERT_IMPL(a_take_needs_beat, take, valid_s1 && out_free, "parser stepped without a held beat or a free output")

endmodule

// File: rtl/core/stdc16_out_stage.sv
// Output register of the telegram deframer: holds one result beat until the sink takes it.
// Depends on stdc16_pkg and the assertion macros header.
`include "scanner_telegram_deframer_crc16_defines.svh"

module stdc16_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic                res_valid,
	input  stdc16_pkg::result_t res,
	output logic                out_free,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,   // data_word, reply_code, frame_status
	output logic [2:0]          m_tuser,   // kind
	output logic                m_tlast
);

	logic load;

	assign out_free = !m_tvalid || m_tready;
	assign load = take && res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= {res.frame_status, res.reply_code, res.data_word};
			m_tuser <= res.kind;
			m_tlast <= res.last_of_frame;
		end
	end

	`STDC16_ASSERT_IMPL(a_load_when_free, load, !m_tvalid || m_tready, "result loaded over a beat not yet taken")
	`STDC16_ASSERT_IMPL(a_data_not_last, m_tvalid && m_tuser == stdc16_pkg::KIND_DATA, !m_tlast, "data word beat marked as frame end")

endmodule
